// ----- rtl/hgt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgt_pkg: shared definitions for the harmonic gait trajectory generator
// Angle format, sine polynomial and trajectory coefficients, and the
// fixed-point helpers used by the pipeline lanes.
// ----------------------------------------------------------------------------
package hgt_pkg;

  // Input and output field widths
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int PHASE_BITS_DEF = 16;

  // Angle: 24 bits per turn, wrapping
  localparam int ANG_BITS = 24;
  localparam logic [ANG_BITS-1:0] QUARTER   = 24'h400000;
  localparam logic [ANG_BITS-1:0] PHI_TURNS = 24'd9078601;

  // Harmonics and lanes: one cosine and one sine lane per harmonic
  localparam int NHARM = 5;
  localparam int NLANE = 2 * NHARM;

  // Q30 Taylor coefficients of sin(pi/2 * u)
  localparam logic signed [31:0] SIN_C0 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C1 = -32'sd693598668;
  localparam logic signed [31:0] SIN_C2 = 32'sd85569306;
  localparam logic signed [31:0] SIN_C3 = -32'sd5026995;
  localparam logic signed [31:0] SIN_C4 = 32'sd172272;

  // Trajectory coefficients times ten, lanes ordered cos k, sin k
  localparam int COEF_W = 18;
  localparam logic signed [COEF_W-1:0] LANE_COEF [NLANE] = '{
    18'sd120700, -18'sd35410,
    -18'sd22480, -18'sd1927,
    -18'sd2080,  18'sd9843,
    -18'sd3739,  18'sd2271,
    -18'sd542,   18'sd2857
  };

  // Accumulator in units of 1/(10 * 2^30) thousandths
  localparam int ACC_W = 52;
  localparam logic signed [ACC_W-1:0] DC_ACC   = 52'(64'sd83610 << 30);
  localparam logic signed [ACC_W-1:0] HALF_ACC = 52'(64'sd5 << 30);

  // Divide by ten: floor(t * RECIP10 / 2^RECIP_SH) is exact for t < 2^22
  localparam int T_W      = 21;
  localparam int RECIP_SH = 24;
  localparam logic [20:0] RECIP10 = 21'd1677722;
  localparam int PROD_W   = 42;

  typedef logic [30:0]        uq_t;   // unsigned Q30, up to 1.0
  typedef logic signed [31:0] sq_t;   // signed Q30

  typedef struct packed {
    uq_t  u;
    logic neg;
  } fold_t;

  // Quarter-wave fold of an angle into the polynomial argument
  function automatic fold_t fold(input logic [ANG_BITS-1:0] a);
    fold_t                f;
    logic [22:0]          x;
    logic [21:0]          r;
    r = a[21:0];
    x = a[22] ? (23'h400000 - {1'b0, r}) : {1'b0, r};
    f.u   = {x, 8'd0};
    f.neg = a[23];
    return f;
  endfunction

  // Q30 square of an unsigned value
  function automatic uq_t usq(input uq_t a);
    logic [61:0] p;
    p = 62'(a) * 62'(a);
    return p[60:30];
  endfunction

  // Q30 product, truncated toward zero
  function automatic sq_t qmul(input sq_t a, input uq_t b);
    logic signed [63:0] aa;
    logic signed [63:0] bb;
    logic signed [63:0] p;
    logic signed [63:0] s;
    aa = 64'(a);
    bb = $signed({33'd0, b});
    p  = aa * bb;
    s  = p[63] ? ((p + 64'sd1073741823) >>> 30) : (p >>> 30);
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/harmonic_gait_trajectory.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: out_valid is high when an item's result leaves the last of
//   15 register stages, one per step.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset: synchronous, active low; clears the stage valid bits only, so no
//   result is strobed until fresh items reach the end of the pipeline.
// ----------------------------------------------------------------------------
// harmonic_gait_trajectory
// Fifth-order Fourier gait trajectory: ten sine lanes (quarter-wave fold,
// Horner polynomial), coefficient products, adder tree and rounded divide.
// ----------------------------------------------------------------------------
module harmonic_gait_trajectory
  import hgt_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [IN_W-1:0]         in_phase,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_trajectory_milli
);

  localparam int NSTG = 15;
  localparam logic [ANG_BITS-1:0] PH_MASK =
    ANG_BITS'((64'd1 << PHASE_BITS) - 64'd1);
  localparam int PH_SH = ANG_BITS - PHASE_BITS;

  // Stage valid bits
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  // Lane payload registers, indexed by stage
  logic [ANG_BITS-1:0]      ang_r  [NHARM];
  uq_t                      u_r    [2:7][NLANE];
  logic                     neg_r  [2:7][NLANE];
  uq_t                      sq_r   [3:6][NLANE];
  sq_t                      p_r    [4:7][NLANE];
  sq_t                      v_r    [NLANE];
  logic signed [ACC_W-1:0]  term_r [NLANE];
  logic signed [ACC_W-1:0]  pair_r [NHARM];
  logic signed [ACC_W-1:0]  sa_r, sb_r, sc_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [T_W-1:0]           t_r;
  logic                     tneg_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     pneg_r;
  logic signed [OUT_W-1:0]  out_r;

  logic [ANG_BITS-1:0]      base;
  fold_t                    fold_w [NLANE];
  logic signed [ACC_W-1:0]  m_nxt;
  logic [17:0]              q_mag;
  logic signed [OUT_W-1:0]  out_nxt;

  // The pipeline takes an item every cycle
  assign busy = 1'b0;

  // Valid bits travel with the data
  assign vld_nxt = {vld_r[NSTG-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Phase scaled to 24 bits per turn
  assign base = ((ANG_BITS'(in_phase)) & PH_MASK) << PH_SH;

  // Stage 1: harmonic angles plus offset
  always_ff @(posedge clk) begin
    for (int h = 0; h < NHARM; h++) begin
      ang_r[h] <= base * ANG_BITS'(h + 1) + PHI_TURNS;
    end
  end

  // Quarter-wave fold; even lanes are cosine (one quarter ahead)
  always_comb begin
    for (int j = 0; j < NLANE; j++) begin
      fold_w[j] = fold(ang_r[j / 2] + ((j % 2 == 0) ? QUARTER : '0));
    end
  end

  // Stages 2 and 3: fold and argument squared; argument, square and sign
  // carried alongside the polynomial
  always_ff @(posedge clk) begin
    for (int j = 0; j < NLANE; j++) begin
      u_r[2][j]   <= fold_w[j].u;
      neg_r[2][j] <= fold_w[j].neg;
      sq_r[3][j]  <= usq(u_r[2][j]);
      for (int s = 3; s <= 7; s++) begin
        u_r[s][j]   <= u_r[s-1][j];
        neg_r[s][j] <= neg_r[s-1][j];
      end
      for (int s = 4; s <= 6; s++) begin
        sq_r[s][j] <= sq_r[s-1][j];
      end
    end
  end

  // Stages 4 to 7: Horner steps, one multiply each
  always_ff @(posedge clk) begin
    for (int j = 0; j < NLANE; j++) begin
      p_r[4][j] <= SIN_C3 + qmul(SIN_C4, sq_r[3][j]);
      p_r[5][j] <= SIN_C2 + qmul(p_r[4][j], sq_r[4][j]);
      p_r[6][j] <= SIN_C1 + qmul(p_r[5][j], sq_r[5][j]);
      p_r[7][j] <= SIN_C0 + qmul(p_r[6][j], sq_r[6][j]);
    end
  end

  // Stage 8: final multiply by the argument, quadrant sign
  always_ff @(posedge clk) begin
    for (int j = 0; j < NLANE; j++) begin
      v_r[j] <= neg_r[7][j] ? -qmul(p_r[7][j], u_r[7][j]) : qmul(p_r[7][j], u_r[7][j]);
    end
  end

  // Stage 9: coefficient products
  always_ff @(posedge clk) begin
    for (int j = 0; j < NLANE; j++) begin
      term_r[j] <= ACC_W'(LANE_COEF[j]) * ACC_W'(v_r[j]);
    end
  end

  // Stages 10 to 12: adder tree with the constant term
  always_ff @(posedge clk) begin
    for (int i = 0; i < NHARM; i++) begin
      pair_r[i] <= term_r[2*i] + term_r[2*i+1];
    end
    sa_r  <= pair_r[0] + pair_r[1];
    sb_r  <= pair_r[2] + pair_r[3];
    sc_r  <= pair_r[4] + DC_ACC;
    acc_r <= sa_r + sb_r + sc_r;
  end

  // Stage 13: magnitude plus half, scaled down by 2^30
  assign m_nxt = acc_r[ACC_W-1] ? (HALF_ACC - acc_r) : (acc_r + HALF_ACC);

  always_ff @(posedge clk) begin
    t_r    <= m_nxt[30 +: T_W];
    tneg_r <= acc_r[ACC_W-1];
  end

  // Stage 14: divide by ten through the reciprocal
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(t_r) * PROD_W'(RECIP10);
    pneg_r <= tneg_r;
  end

  // Stage 15: sign and saturation
  assign q_mag = prod_r[RECIP_SH +: 18];

  always_comb begin
    if (pneg_r) begin
      if (q_mag > 18'd32768) begin
        out_nxt = -16'sd32768;
      end else begin
        out_nxt = OUT_W'(-$signed({1'b0, q_mag}));
      end
    end else begin
      if (q_mag > 18'd32767) begin
        out_nxt = 16'sd32767;
      end else begin
        out_nxt = OUT_W'(q_mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid            = vld_r[NSTG-1];
  assign out_trajectory_milli = out_r;

endmodule
`default_nettype wire

// ----- rtl/hgt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgt_checker: port-level checks for the trajectory generator
// Fixed latency, no results out of reset, and the output range.
// ----------------------------------------------------------------------------
module hgt_checker
  import hgt_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    out_valid,
  input wire logic signed [OUT_W-1:0] out_trajectory_milli
);

  // Every accepted item gives a result once it has passed all stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##15 out_valid)
    else $error("item accepted without a result at fixed latency");

  // No result appears without a matching accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 15))
    else $error("result strobed with no matching item");

  // Reset drains the pipeline at once
  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result strobed just after reset");

  // Output stays within the trajectory's reach
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_trajectory_milli >= -16'sd12000 &&
                   out_trajectory_milli <= 16'sd29000))
    else $error("trajectory out of range");

endmodule

bind harmonic_gait_trajectory hgt_checker u_hgt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_trajectory_milli (out_trajectory_milli)
);
`default_nettype wire
